[design/esest_pkg.sv]
`default_nettype none
package esest_pkg;

    localparam int SAMPLES = 5;
    localparam int SLOT_W  = $clog2(SAMPLES);

    localparam int DATA_W  = 32;
    localparam int FILT_W  = 40;
    localparam int WGT_W   = 9;
    localparam int DPC_W   = 16;
    localparam int K_W     = 14;
    localparam int MCAND_W = DPC_W + K_W;
    localparam int PROD_W  = FILT_W + MCAND_W;
    // 1e6 / 65536 = 15625 / 1024
    localparam int SCALE_SH = 10;
    localparam int DVD_W   = PROD_W - SCALE_SH;
    localparam int MUL_STEPS = MCAND_W;
    localparam int DIV_STEPS = DATA_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic [K_W-1:0]   SPEED_K     = K_W'(15625);
    localparam logic [WGT_W-1:0] WGT_FULL    = WGT_W'(256);
    localparam logic [WGT_W-1:0] WGT_RESET   = WGT_W'(51);
    localparam logic [DPC_W-1:0] DPC_RESET   = DPC_W'(9830);

    localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
    localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};

    localparam logic [DATA_W-1:0] SPEED_POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SPEED_NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

    // register index, taken from paddr[2]
    localparam logic REG_WEIGHT = 1'b0;
    localparam logic REG_DPC    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT_A,
        ST_FILT_B,
        ST_START,
        ST_CALC,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } t_md_state;

    typedef struct packed {
        logic done;
        logic sat;
    } t_md_stat;

endpackage
`default_nettype wire

[design/esest_muldiv.sv]
`default_nettype none
module esest_muldiv (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [esest_pkg::FILT_W-1:0]   i_value,
    input  wire logic [esest_pkg::MCAND_W-1:0]         i_mcand,
    input  wire logic [esest_pkg::DATA_W-1:0]          i_span,
    output esest_pkg::t_md_stat                        o_stat,
    output logic [esest_pkg::DATA_W-2:0]               o_quot
);
    import esest_pkg::*;

    t_md_state r_state, n_state;
    logic [STEP_W-1:0]         r_step;
    logic [PROD_W-1:0]         r_prod;
    logic [FILT_W-1:0]         r_mag;
    logic [DATA_W-1:0]         r_span;
    logic [2*DATA_W-1:0]       r_div;
    logic                      r_sat;

    logic [FILT_W:0]           mul_sum;
    logic                      ovf;
    logic [DATA_W:0]           top;
    logic [DATA_W:0]           diff;
    logic                      ge;
    logic                      mul_last;
    logic                      div_last;

    // product = {hi, multiplier bits not yet consumed}
    assign mul_sum = {1'b0, r_prod[PROD_W-1:MCAND_W]} +
                     (r_prod[0] ? {1'b0, r_mag} : '0);
    // quotient must fit in DATA_W bits, so the dividend high part is below span
    assign ovf  = {{(2*DATA_W-DVD_W){1'b0}}, r_prod[PROD_W-1:SCALE_SH+DATA_W]} >= r_span;
    assign top  = r_div[2*DATA_W-1:DATA_W-1];
    assign diff = top - {1'b0, r_span};
    assign ge   = ~diff[DATA_W];
    assign mul_last = (r_step == STEP_W'(MUL_STEPS-1));
    assign div_last = (r_step == STEP_W'(DIV_STEPS-1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            MD_IDLE: if (i_start) n_state = MD_MUL;
            MD_MUL:  if (mul_last) n_state = MD_CHK;
            MD_CHK:  n_state = ovf ? MD_DONE : MD_DIV;
            MD_DIV:  if (div_last) n_state = MD_DONE;
            MD_DONE: n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    always_comb begin
        o_stat.done = (r_state == MD_DONE);
        o_stat.sat  = r_sat | r_div[DATA_W-1];
        o_quot      = r_div[DATA_W-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == MD_MUL || r_state == MD_DIV) begin
                r_step <= (mul_last && r_state == MD_MUL) ? '0 : r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MD_IDLE: begin
                if (i_start) begin
                    r_mag  <= i_value[FILT_W-1] ? FILT_W'(-i_value) : i_value;
                    r_prod <= {{FILT_W{1'b0}}, i_mcand};
                    r_span <= i_span;
                end
            end
            MD_MUL: begin
                r_prod <= {mul_sum, r_prod[MCAND_W-1:1]};
            end
            MD_CHK: begin
                r_sat <= ovf;
                r_div <= {{(2*DATA_W-DVD_W){1'b0}}, r_prod[PROD_W-1:SCALE_SH]};
            end
            MD_DIV: begin
                r_div <= {(ge ? diff[DATA_W-1:0] : top[DATA_W-1:0]),
                          r_div[DATA_W-2:0], ge};
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[design/encoder_speed_estimator.sv]
// Encoder speed estimator: windowed count difference, IIR low-pass, scaled divide.
// While the window fills, a sample goes straight to its result; otherwise it passes the
// FILT_A and FILT_B states and the scaled divide (the divide step is skipped when the
// quotient saturates, and the multiply and divide for a zero time span).
// One item at a time: the 30-step serial multiply and 32-step restoring divide set the
// time per item; the next item can be taken in the cycle after the result is registered.
// Reset (synchronous, active low) empties the window and clears the filter.
`default_nettype none
module encoder_speed_estimator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] sample_count, [63:32] sample_time_us
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] speed
    output logic [1:0]       o_m_tuser,   // [0] ready_res, [1] span_zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import esest_pkg::*;

    t_state r_state, n_state;

    logic [WGT_W-1:0]  r_weight;
    logic [DPC_W-1:0]  r_dpc;

    logic [DATA_W-1:0] r_cnt_ring [SAMPLES];
    logic [DATA_W-1:0] r_time_ring [SAMPLES];
    logic [SLOT_W-1:0] r_slot;
    logic              r_filled;

    logic [DATA_W-1:0] r_cnt, r_t, r_old_cnt, r_old_t, r_span;
    logic signed [WGT_W+DATA_W+1:0]   r_wd;
    logic signed [FILT_W+WGT_W:0]     r_tmp;
    logic signed [FILT_W-1:0]         r_filt;
    logic [MCAND_W-1:0]               r_mcand;

    logic [DATA_W-1:0] r_res_speed;
    logic              r_res_ready, r_res_sz;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_speed;
    logic              r_ready_res, r_span_zero;

    logic              s_accept, md_start, load_out, cfg_wr;
    logic [SLOT_W-1:0] oldest;
    logic [WGT_W-1:0]  w_clamp;
    logic signed [WGT_W:0]    w_new, w_keep;
    logic signed [DATA_W:0]   d;
    logic signed [FILT_W+WGT_W+1:0] f_sum;
    logic signed [FILT_W-1:0] f_sat;
    logic [DATA_W-1:0] calc_speed;
    t_md_stat          md_stat;
    logic [DATA_W-2:0] md_quot;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_DPC) ? {{(32-DPC_W){1'b0}}, r_dpc}
                                          : {{(32-WGT_W){1'b0}}, r_weight};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WGT_RESET;
            r_dpc    <= DPC_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_DPC) begin
                r_dpc <= pwdata[DPC_W-1:0];
            end else begin
                r_weight <= pwdata[WGT_W-1:0];
            end
        end
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = r_filled ? ST_FILT_A : ST_DONE;
            ST_FILT_A: n_state = ST_FILT_B;
            ST_FILT_B: n_state = (r_span == '0) ? ST_DONE : ST_START;
            ST_START:  n_state = ST_CALC;
            ST_CALC:   if (md_stat.done) n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        md_start   = (r_state == ST_START);
        load_out   = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);
    end

    assign s_accept = i_s_tvalid & o_s_tready;
    assign oldest   = (r_slot == SLOT_W'(SAMPLES-1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_filled    <= 1'b0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_slot <= oldest;
                if (r_slot == SLOT_W'(SAMPLES-1)) r_filled <= 1'b1;
            end
            if (r_state == ST_FILT_B) r_filt <= f_sat;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- sample window ----------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cnt_ring[r_slot]  <= i_s_tdata[DATA_W-1:0];
            r_time_ring[r_slot] <= i_s_tdata[2*DATA_W-1:DATA_W];
            r_old_cnt <= r_cnt_ring[oldest];
            r_old_t   <= r_time_ring[oldest];
            r_cnt     <= i_s_tdata[DATA_W-1:0];
            r_t       <= i_s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // ---------------- low-pass filter ----------------
    assign w_clamp = (r_weight > WGT_FULL) ? WGT_FULL : r_weight;
    assign w_new   = $signed({1'b0, w_clamp});
    assign w_keep  = $signed({1'b0, WGT_W'(WGT_FULL - w_clamp)});
    assign d       = $signed({r_cnt[DATA_W-1], r_cnt}) - $signed({r_old_cnt[DATA_W-1], r_old_cnt});
    // arithmetic shift gives the floor of the divide by 256
    assign f_sum   = (FILT_W+WGT_W+2)'(r_wd) + (FILT_W+WGT_W+2)'(r_tmp >>> 8);
    assign f_sat   = (f_sum > (FILT_W+WGT_W+2)'(FILT_MAX)) ? FILT_MAX :
                     (f_sum < (FILT_W+WGT_W+2)'(FILT_MIN)) ? FILT_MIN :
                     f_sum[FILT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FILT_A) begin
            r_span  <= r_t - r_old_t;
            r_wd    <= w_new * d;
            r_tmp   <= w_keep * r_filt + (FILT_W+WGT_W+1)'(128);
            r_mcand <= MCAND_W'(r_dpc * SPEED_K);
        end
    end

    // ---------------- scale and divide ----------------
    esest_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_value (r_filt),
        .i_mcand (r_mcand),
        .i_span  (r_span),
        .o_stat  (md_stat),
        .o_quot  (md_quot)
    );

    always_comb begin
        if (r_filt[FILT_W-1]) begin
            calc_speed = md_stat.sat ? SPEED_NEG_MAX : DATA_W'(-{1'b0, md_quot});
        end else begin
            calc_speed = md_stat.sat ? SPEED_POS_MAX : {1'b0, md_quot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && !r_filled) begin
            r_res_speed <= '0;
            r_res_ready <= 1'b0;
            r_res_sz    <= 1'b0;
        end
        if (r_state == ST_FILT_B) begin
            r_res_speed <= '0;
            r_res_ready <= 1'b1;
            r_res_sz    <= (r_span == '0);
        end
        if (r_state == ST_CALC && md_stat.done) begin
            r_res_speed <= calc_speed;
        end
        if (load_out) begin
            r_speed     <= r_res_speed;
            r_ready_res <= r_res_ready;
            r_span_zero <= r_res_sz;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_speed;
    assign o_m_tuser  = {r_span_zero, r_ready_res};

endmodule
`default_nettype wire

[verif/encoder_speed_estimator_tb.sv]
`default_nettype none
module encoder_speed_estimator_tb;
    import esest_pkg::*;

    typedef struct packed {
        logic [31:0] speed;
        logic        ready_res;
        logic        span_zero;
    } speed_res_t;

    typedef struct packed {
        logic [31:0] cnt;
        logic [31:0] tm;
        logic        typed;
        speed_res_t  res;
    } dir_row_t;

    localparam speed_res_t RES_FILL      = '{speed: 32'd0, ready_res: 1'b0, span_zero: 1'b0};
    localparam speed_res_t RES_ZERO_SPAN = '{speed: 32'd0, ready_res: 1'b1, span_zero: 1'b1};

    localparam int N_DIR            = 20;
    localparam int N_PHASES         = 8;
    localparam int PHASE_ITEMS      = 110;
    localparam int HOLD_BURST       = 25;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT   = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    encoder_speed_estimator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [31:0] sample_count, [63:32] sample_time_us
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // [31:0] speed
        .o_m_tuser  (o_m_tuser),    // [0] ready_res, [1] span_zero
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // speed model state
    logic [31:0]      cnt_ring [SAMPLES];
    logic [31:0]      tm_ring  [SAMPLES];
    longint           filt_state;
    int unsigned      slot_idx;
    int unsigned      fill_lvl;
    logic [WGT_W-1:0] filt_wgt;
    logic [DPC_W-1:0] deg_per_count;

    speed_res_t expected_speeds [$];
    int         n_errors = 0;
    int         idle_cycles = 0;

    // result sink control
    logic sink_hold_req  = 1'b0;
    logic sink_hold_done = 1'b0;
    int   sink_stall_pct = 25;
    int   sink_wait;

    dir_row_t dir_rows [N_DIR] = '{
        // window fill
        '{32'd0,          32'd0,          1'b1, RES_FILL},
        '{32'd100,        32'd1000,       1'b1, RES_FILL},
        '{32'hFFFF_FF9C,  32'd2000,       1'b1, RES_FILL},
        '{32'h7FFF_FFFF,  32'd3000,       1'b1, RES_FILL},
        '{32'h8000_0000,  32'd4000,       1'b1, RES_FILL},
        // first estimate, huge time span
        '{32'd200,        32'hFFFF_FFFF,  1'b0, RES_FILL},
        '{32'h7FFF_FFFF,  32'd2000,       1'b1, RES_ZERO_SPAN},
        // most negative count step over one microsecond
        '{32'h8000_0000,  32'd3001,       1'b0, RES_FILL},
        '{32'h7FFF_FFFF,  32'd4000,       1'b1, RES_ZERO_SPAN},
        '{32'h8000_0000,  32'hFFFF_FFFF,  1'b1, RES_ZERO_SPAN},
        // timestamp wraps
        '{32'd0,          32'd0,          1'b0, RES_FILL},
        '{32'd5,          32'd3002,       1'b0, RES_FILL},
        '{32'hFFFF_FFFF,  32'd4001,       1'b0, RES_FILL},
        '{32'h5555_5555,  32'hAAAA_AAAA,  1'b0, RES_FILL},
        '{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, RES_FILL},
        // large positive steps, one microsecond spans: speed saturation
        '{32'h7FFF_FFFF,  32'd3003,       1'b0, RES_FILL},
        '{32'h7FFF_FFFF,  32'd4002,       1'b0, RES_FILL},
        '{32'h7FFF_FFFF,  32'hAAAA_AAAB,  1'b0, RES_FILL},
        '{32'h7FFF_FFFF,  32'h5555_5556,  1'b0, RES_FILL},
        '{32'd0,          32'd3003,       1'b1, RES_ZERO_SPAN}
    };

    function automatic speed_res_t estimate_speed(input logic [31:0] cnt,
                                                  input logic [31:0] tm);
        speed_res_t        res;
        int unsigned       oldest;
        longint            diff;
        longint            wgt;
        longint            filt;
        logic [31:0]       span;
        longint unsigned   mag;
        longint unsigned   prod;
        longint unsigned   den;
        longint unsigned   quo;
        res = RES_FILL;
        cnt_ring[slot_idx] = cnt;
        tm_ring[slot_idx]  = tm;
        if (fill_lvl < SAMPLES) begin
            slot_idx = (slot_idx + 1) % SAMPLES;
            fill_lvl++;
            return res;
        end
        oldest = (slot_idx + 1) % SAMPLES;
        diff = longint'($signed(cnt)) - longint'($signed(cnt_ring[oldest]));
        span = tm - tm_ring[oldest];
        wgt  = (filt_wgt > WGT_FULL) ? longint'(WGT_FULL) : longint'(filt_wgt);
        // arithmetic shift gives the floor of the rounded Q8 product
        filt = wgt * diff + (((longint'(WGT_FULL) - wgt) * filt_state + 128) >>> 8);
        if (filt > longint'(FILT_MAX))
            filt = longint'(FILT_MAX);
        if (filt < longint'(FILT_MIN))
            filt = longint'(FILT_MIN);
        filt_state = filt;
        slot_idx   = oldest;
        res.ready_res = 1'b1;
        if (span == 32'd0) begin
            res.span_zero = 1'b1;
            return res;
        end
        mag  = (filt < 0) ? unsigned'(-filt) : unsigned'(filt);
        prod = mag * 64'(deg_per_count);
        den  = 64'(span) << SCALE_SH;
        quo  = (prod / den) * 64'(SPEED_K) + ((prod % den) * 64'(SPEED_K)) / den;
        if (filt < 0)
            res.speed = (quo >= 64'h8000_0000) ? SPEED_NEG_MAX : 32'(64'd0 - quo);
        else
            res.speed = (quo > 64'h7FFF_FFFF) ? SPEED_POS_MAX : quo[31:0];
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic apb_xfer(input logic wr, input logic sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic sel, input logic [31:0] want);
        logic [31:0] got;
        apb_xfer(1'b0, sel, 32'd0, got);
        if (got !== want) begin
            $display("%0t: register %0d readback expected %h actual %h", $time, sel, want, got);
            n_errors++;
        end
    endtask

    task automatic set_register(input logic sel, input logic [31:0] value);
        logic [31:0] unused;
        apb_xfer(1'b1, sel, value, unused);
        if (sel == REG_WEIGHT) begin
            filt_wgt = value[WGT_W-1:0];
            check_register(sel, 32'(filt_wgt));
        end else begin
            deg_per_count = value[DPC_W-1:0];
            check_register(sel, 32'(deg_per_count));
        end
    endtask

    task automatic send_sample(input logic [31:0] cnt, input logic [31:0] tm,
                               input logic typed, input speed_res_t typed_res);
        speed_res_t res;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {tm, cnt};
        do @(posedge i_clk); while (!o_s_tready);
        res = estimate_speed(cnt, tm);
        expected_speeds.push_back(typed ? typed_res : res);
    endtask

    task automatic source_gap();
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result sink with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_wait  <= 0;
        end else if (sink_hold_req && !sink_hold_done) begin
            i_m_tready     <= 1'b0;
            sink_wait      <= SINK_HOLD_CYCLES;
            sink_hold_done <= 1'b1;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            i_m_tready <= 1'b0;
            sink_wait  <= pick_gap();
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    speed_res_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_speeds.size() == 0) begin
                $display("%0t: unexpected result, actual speed %h flags %b",
                         $time, o_m_tdata, o_m_tuser);
                n_errors++;
            end else begin
                want = expected_speeds.pop_front();
                if (o_m_tdata !== want.speed) begin
                    $display("%0t: speed expected %h actual %h", $time, want.speed, o_m_tdata);
                    n_errors++;
                end
                if (o_m_tuser[0] !== want.ready_res) begin
                    $display("%0t: ready_res expected %b actual %b",
                             $time, want.ready_res, o_m_tuser[0]);
                    n_errors++;
                end
                if (o_m_tuser[1] !== want.span_zero) begin
                    $display("%0t: span_zero expected %b actual %b",
                             $time, want.span_zero, o_m_tuser[1]);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles without any transaction on any port
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] cnt;
        logic [31:0] tm;
        logic [31:0] walk_cnt;
        logic [31:0] walk_tm;
        logic [31:0] wgt_val;
        logic [31:0] dpc_val;
        int unsigned pick;
        logic        tx_gaps_on;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 64'd0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 3'd0;
        pwdata     <= 32'd0;

        filt_state    = 0;
        slot_idx      = 0;
        fill_lvl      = 0;
        filt_wgt      = WGT_RESET;
        deg_per_count = DPC_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_register(REG_WEIGHT, 32'(WGT_RESET));
        check_register(REG_DPC, 32'(DPC_RESET));

        for (int k = 0; k < N_DIR; k++) begin
            send_sample(dir_rows[k].cnt, dir_rows[k].tm, dir_rows[k].typed, dir_rows[k].res);
            if (k != N_DIR - 1)
                source_gap();
        end
        i_s_tvalid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            while (expected_speeds.size() != 0) @(posedge i_clk);
            case (p)
                0: begin wgt_val = 32'd51;  dpc_val = 32'd9830;  end
                1: begin wgt_val = 32'd0;   dpc_val = 32'd1;     end
                2: begin wgt_val = 32'd256; dpc_val = 32'd65535; end
                3: begin wgt_val = 32'd511; dpc_val = 32'd40000; end // weight above full scale
                4: begin wgt_val = 32'd128; dpc_val = 32'd0;     end
                5: begin wgt_val = 32'd1;   dpc_val = 32'd65535; end
                default: begin
                    wgt_val = $urandom_range(0, 256);
                    dpc_val = $urandom_range(1, 65535);
                end
            endcase
            set_register(REG_WEIGHT, wgt_val);
            set_register(REG_DPC, dpc_val);

            tx_gaps_on = (p % 3 != 1);
            sink_stall_pct <= (p % 3 == 2) ? 0 : 25;
            if (p == 0)
                sink_hold_req <= 1'b1;

            walk_cnt = $urandom;
            walk_tm  = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    // plausible motion: mostly small count steps, rising timestamps
                    if ($urandom_range(0, 19) == 0)
                        walk_cnt = walk_cnt + $urandom;
                    else
                        walk_cnt = walk_cnt + $urandom_range(0, 400) - 200;
                    walk_tm = walk_tm + $urandom_range(1, 3000);
                    cnt = walk_cnt;
                    tm  = walk_tm;
                end else if (pick < 87) begin
                    // repeat the timestamp of the oldest window entry
                    cnt = walk_cnt + $urandom_range(0, 15);
                    tm  = tm_ring[(slot_idx + 1) % SAMPLES];
                end else begin
                    cnt = $urandom;
                    tm  = $urandom;
                end
                send_sample(cnt, tm, 1'b0, RES_FILL);
                if (tx_gaps_on && !(p == 0 && i < HOLD_BURST) && i != PHASE_ITEMS - 1)
                    source_gap();
            end
            i_s_tvalid <= 1'b0;
        end

        while (expected_speeds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
design/esest_pkg.sv
design/esest_muldiv.sv
design/encoder_speed_estimator.sv
verif/encoder_speed_estimator_tb.sv
